### design/shl_pkg.sv
package shl_pkg;

  typedef enum logic [3:0] {
    CLS_DEFAULT = 4'd0,
    CLS_SYMBOL  = 4'd1,
    CLS_DIGITS  = 4'd2,
    CLS_BLOCK   = 4'd3,
    CLS_LINE    = 4'd4,
    CLS_SQ      = 4'd5,
    CLS_DQ      = 4'd6,
    CLS_TDQ     = 4'd7,
    CLS_TSQ     = 4'd8,
    CLS_TDQ_S   = 4'd9,
    CLS_TSQ_S   = 4'd10,
    CLS_ASSIGN  = 4'd11
  } cls_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_C      = 2'd1,
    MODE_LISP   = 2'd2,
    MODE_PYTHON = 2'd3
  } mode_t;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;

  typedef struct packed {
    logic [7:0] char_now;
    logic [7:0] char_next;
    logic [7:0] char_after_next;
    logic       start;
  } shl_item_t;

  typedef struct packed {
    cls_t       cur;
    cls_t       pend;
    logic [1:0] skip;
  } shl_state_t;

  localparam shl_state_t STATE_RESET = '{cur: CLS_DEFAULT, pend: CLS_DEFAULT, skip: 2'd0};

  // punctuation set, plus the two UTF-8 bytes of the pound sign
  function automatic logic sym_byte(input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    case (b) inside
      8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h21, 8'h27, 8'hC2, 8'hA3,
      8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h2D, 8'h2B, 8'h3D, 8'h3A, 8'h3B,
      8'h40, 8'h7E, 8'h23, 8'h3C, 8'h3E, 8'h2C, 8'h2E, 8'h3F, 8'h2F, 8'h5C,
      8'h7C: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

### design/shl_rules.sv
module shl_rules import shl_pkg::*; (
  input  mode_t      mode,
  input  shl_item_t  item,
  input  shl_state_t state_in,
  output cls_t       res,
  output shl_state_t state_next
);

  shl_state_t base;
  cls_t       st;
  cls_t       doc_cls;
  cls_t       asg_cls;
  logic [7:0] a, b, c;
  logic       cm, lm, pm, cp;
  logic       triple_d, triple_s;
  logic       quote_free;

  assign a = item.char_now;
  assign b = item.char_next;
  assign c = item.char_after_next;

  assign cm = (mode == MODE_C);
  assign lm = (mode == MODE_LISP);
  assign pm = (mode == MODE_PYTHON);
  assign cp = cm || pm;

  assign triple_d = (a == CH_DQUOTE) && (b == CH_DQUOTE) && (c == CH_DQUOTE);
  assign triple_s = (a == CH_SQUOTE) && (b == CH_SQUOTE) && (c == CH_SQUOTE);
  assign doc_cls  = triple_d ? CLS_TDQ : CLS_TSQ;
  assign asg_cls  = triple_d ? CLS_TDQ_S : CLS_TSQ_S;
  assign quote_free = (a != CH_SQUOTE) && (b != CH_SQUOTE) && (c != CH_SQUOTE) &&
                      (a != CH_DQUOTE) && (b != CH_DQUOTE) && (c != CH_DQUOTE);

  always_comb begin
    base = item.start ? STATE_RESET : state_in;
    st = base.pend;
    state_next = base;
    res = base.cur;
    if (base.skip != 2'd0) begin
      state_next.skip = base.skip - 2'd1;
    end else begin
      state_next.cur = st;
      res = st;
      if (pm && st == CLS_DEFAULT && a == CH_EQUALS && b != CH_EQUALS) begin
        state_next.pend = CLS_ASSIGN;
        state_next.cur = CLS_ASSIGN;
        res = CLS_ASSIGN;
      end else if (pm && st == CLS_ASSIGN &&
                   (a == CH_SPACE || a == CH_TAB || a == CH_LF)) begin
        state_next.pend = CLS_ASSIGN;
        res = CLS_ASSIGN;
      end else if (pm && st == CLS_ASSIGN && a == CH_DQUOTE && b != CH_DQUOTE) begin
        state_next.pend = CLS_DQ;
        res = CLS_DQ;
      end else if (pm && st == CLS_ASSIGN && a == CH_SQUOTE && b != CH_SQUOTE) begin
        state_next.pend = CLS_SQ;
        res = CLS_SQ;
      end else if (pm && st == CLS_ASSIGN && quote_free) begin
        state_next.pend = CLS_DEFAULT;
        state_next.cur = CLS_DEFAULT;
        res = CLS_DEFAULT;
      end else if (cm && st == CLS_DEFAULT && a == CH_SLASH && b == CH_STAR) begin
        state_next.skip = 2'd1;
        state_next.pend = CLS_BLOCK;
        state_next.cur = CLS_BLOCK;
        res = CLS_BLOCK;
      end else if (cm && st == CLS_BLOCK && a == CH_STAR && b == CH_SLASH) begin
        state_next.skip = 2'd1;
        state_next.pend = CLS_DEFAULT;
        res = CLS_BLOCK;
      end else if (st == CLS_DEFAULT && ((cm && a == CH_SLASH && b == CH_SLASH) ||
                   (lm && a == CH_SEMI) || (pm && a == CH_HASH))) begin
        state_next.skip = 2'd1;
        state_next.pend = CLS_LINE;
        state_next.cur = CLS_LINE;
        res = CLS_LINE;
      end else if (mode != MODE_NONE && st == CLS_LINE && a == CH_LF) begin
        state_next.pend = CLS_DEFAULT;
        res = CLS_DEFAULT;
      end else if (pm && (triple_d || triple_s) &&
                   (st == CLS_DEFAULT || st == CLS_ASSIGN)) begin
        // opening triple quote, kind set by what precedes it
        state_next.skip = 2'd2;
        state_next.pend = (st == CLS_DEFAULT) ? doc_cls : asg_cls;
        state_next.cur = (st == CLS_DEFAULT) ? doc_cls : asg_cls;
        res = (st == CLS_DEFAULT) ? doc_cls : asg_cls;
      end else if (pm && (triple_d || triple_s) && (st == doc_cls || st == asg_cls)) begin
        state_next.skip = 2'd2;
        state_next.pend = CLS_DEFAULT;
        res = st;
      end else if (cp && st == CLS_DEFAULT && a == CH_DQUOTE) begin
        state_next.pend = CLS_DQ;
        res = CLS_DQ;
      end else if (cp && st == CLS_DQ && a == CH_BSLASH) begin
        state_next.skip = 2'd1;
        state_next.pend = CLS_DQ;
        res = CLS_DQ;
      end else if (cp && st == CLS_DQ && a == CH_DQUOTE) begin
        state_next.pend = CLS_DEFAULT;
        res = CLS_DQ;
      end else if (cp && st == CLS_DEFAULT && a == CH_SQUOTE) begin
        state_next.pend = CLS_SQ;
        res = CLS_SQ;
      end else if (cp && st == CLS_SQ && a == CH_BSLASH) begin
        state_next.skip = 2'd1;
        state_next.pend = CLS_SQ;
        res = CLS_SQ;
      end else if (cp && st == CLS_SQ && a == CH_SQUOTE) begin
        state_next.pend = CLS_DEFAULT;
        res = CLS_SQ;
      end else if (st != CLS_DEFAULT) begin
        state_next.pend = st;
        res = st;
      end else if (a >= CH_ZERO && a <= CH_NINE) begin
        state_next.pend = CLS_DEFAULT;
        state_next.cur = CLS_DIGITS;
        res = CLS_DIGITS;
      end else if (sym_byte(a)) begin
        state_next.pend = CLS_DEFAULT;
        state_next.cur = CLS_SYMBOL;
        res = CLS_SYMBOL;
      end else begin
        state_next.pend = st;
        res = st;
      end
    end
  end

endmodule

### design/syntax_highlight_classifier_unit.sv
// Syntax highlight classifier: one highlight class per text byte.
// Input channel (in_valid / in_stall): char_now with two bytes of lookahead
// and start_of_text, which clears the parser state before that byte.
// Output channel (out_valid / out_stall): highlight_class, one item for each
// input item, in order.
// Config channel (cfg_valid / cfg_ready): language_mode, 0 none, 1 C,
// 2 Lisp, 3 Python. cfg_ready is always high; write only while idle.
// The class rules and the state update are combinational between the input
// register and the output register: an item held in the input register has
// its class written to the output register when that register can load.
// Throughput: one item per cycle while the output is not stalled.
// A stalled output holds its item; the input register still takes one more
// item, after which in_stall rises until the output moves on.
// Reset (rst, synchronous): both stages empty, parser state to default,
// language mode none.
module syntax_highlight_classifier_unit import shl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_now,
  input  logic [7:0] char_next,
  input  logic [7:0] char_after_next,
  input  logic       start_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] highlight_class,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] language_mode
);

  shl_item_t  s1;
  logic       s1_valid;
  shl_state_t state;
  shl_state_t state_next;
  mode_t      mode;
  cls_t       res;
  logic       out_load;
  logic       s1_load;
  logic       s1_move;

  assign out_load  = !out_valid || !out_stall;
  assign s1_move   = s1_valid && out_load;
  assign s1_load   = !s1_valid || out_load;
  assign in_stall  = !s1_load;
  assign cfg_ready = 1'b1;

  shl_rules u_rules (
    .mode       (mode),
    .item       (s1),
    .state_in   (state),
    .res        (res),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_RESET;
      mode      <= MODE_NONE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= mode_t'(language_mode);
      end
      if (s1_load) begin
        s1_valid <= in_valid;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
      if (s1_move) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_load) begin
      s1 <= '{char_now: char_now, char_next: char_next,
              char_after_next: char_after_next, start: start_of_text};
    end
    if (s1_move) begin
      highlight_class <= res;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  a_skip_range: assert property (@(posedge clk) disable iff (rst)
    state.skip != 2'd3)
    else $error("skip count out of range");

  a_skip_holds_class: assert property (@(posedge clk) disable iff (rst)
    s1_move && !s1.start && state.skip != 2'd0 |=> highlight_class == $past(state.cur))
    else $error("skipped byte lost the token class");

endmodule

### tb/syntax_highlight_classifier_unit_tb.sv
module syntax_highlight_classifier_unit_tb import shl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  class highlight_tracker;
    mode_t lang;
    cls_t cur;
    cls_t pend;
    bit [1:0] skip;
    cls_t classes_due[$];
    int unsigned mismatches;
    int unsigned checked;
    bit [11:0] classes_seen;

    function new();
      lang = MODE_NONE;
      cur = CLS_DEFAULT;
      pend = CLS_DEFAULT;
      skip = 2'd0;
      mismatches = 0;
      checked = 0;
      classes_seen = '0;
    endfunction

    function bit punct_byte(logic [7:0] b);
      case (b)
        8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h21, 8'h27, 8'hC2, 8'hA3,
        8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h2D, 8'h2B, 8'h3D, 8'h3A, 8'h3B,
        8'h40, 8'h7E, 8'h23, 8'h3C, 8'h3E, 8'h2C, 8'h2E, 8'h3F, 8'h2F, 8'h5C,
        8'h7C: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function cls_t classify_byte(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      bit cm = (lang == MODE_C);
      bit lm = (lang == MODE_LISP);
      bit pm = (lang == MODE_PYTHON);
      bit cp = cm || pm;
      bit tri_d = (a == CH_DQUOTE && b == CH_DQUOTE && c == CH_DQUOTE);
      bit tri_s = (a == CH_SQUOTE && b == CH_SQUOTE && c == CH_SQUOTE);
      cls_t st;
      cls_t doc;
      cls_t asg;
      cls_t opener;
      if (skip != 2'd0) begin
        skip--;
        return cur;
      end
      st = pend;
      cur = st;
      // python assignment and what may follow it
      if (pm && st == CLS_DEFAULT && a == CH_EQUALS && b != CH_EQUALS) begin
        pend = CLS_ASSIGN;
        cur = CLS_ASSIGN;
        return CLS_ASSIGN;
      end
      if (pm && st == CLS_ASSIGN && (a == CH_SPACE || a == CH_TAB || a == CH_LF)) begin
        pend = CLS_ASSIGN;
        cur = CLS_ASSIGN;
        return CLS_ASSIGN;
      end
      if (pm && st == CLS_ASSIGN && a == CH_DQUOTE && b != CH_DQUOTE) begin
        pend = CLS_DQ;
        return CLS_DQ;
      end
      if (pm && st == CLS_ASSIGN && a == CH_SQUOTE && b != CH_SQUOTE) begin
        pend = CLS_SQ;
        return CLS_SQ;
      end
      if (pm && st == CLS_ASSIGN && a != CH_SQUOTE && b != CH_SQUOTE && c != CH_SQUOTE
          && a != CH_DQUOTE && b != CH_DQUOTE && c != CH_DQUOTE) begin
        pend = CLS_DEFAULT;
        cur = CLS_DEFAULT;
        return CLS_DEFAULT;
      end
      if (cm && st == CLS_DEFAULT && a == CH_SLASH && b == CH_STAR) begin
        skip = 2'd1;
        pend = CLS_BLOCK;
        cur = CLS_BLOCK;
        return CLS_BLOCK;
      end
      if (cm && st == CLS_BLOCK && a == CH_STAR && b == CH_SLASH) begin
        skip = 2'd1;
        pend = CLS_DEFAULT;
        return CLS_BLOCK;
      end
      if (st == CLS_DEFAULT && ((cm && a == CH_SLASH && b == CH_SLASH) ||
          (lm && a == CH_SEMI) || (pm && a == CH_HASH))) begin
        skip = 2'd1;
        pend = CLS_LINE;
        cur = CLS_LINE;
        return CLS_LINE;
      end
      if ((cm || lm || pm) && st == CLS_LINE && a == CH_LF) begin
        pend = CLS_DEFAULT;
        return CLS_DEFAULT;
      end
      if (pm && (tri_d || tri_s)) begin
        doc = tri_d ? CLS_TDQ : CLS_TSQ;
        asg = tri_d ? CLS_TDQ_S : CLS_TSQ_S;
        opener = CLS_DEFAULT;
        if (st == CLS_DEFAULT) opener = doc;
        else if (st == CLS_ASSIGN) opener = asg;
        if (opener != CLS_DEFAULT) begin
          skip = 2'd2;
          pend = opener;
          cur = opener;
          return opener;
        end
        if (st == doc || st == asg) begin
          skip = 2'd2;
          pend = CLS_DEFAULT;
          return st;
        end
      end
      if (cp && st == CLS_DEFAULT && a == CH_DQUOTE) begin
        pend = CLS_DQ;
        return CLS_DQ;
      end
      if (cp && st == CLS_DQ && a == CH_BSLASH) begin
        skip = 2'd1;
        pend = CLS_DQ;
        return CLS_DQ;
      end
      if (cp && st == CLS_DQ && a == CH_DQUOTE) begin
        pend = CLS_DEFAULT;
        return CLS_DQ;
      end
      if (cp && st == CLS_DEFAULT && a == CH_SQUOTE) begin
        pend = CLS_SQ;
        return CLS_SQ;
      end
      if (cp && st == CLS_SQ && a == CH_BSLASH) begin
        skip = 2'd1;
        pend = CLS_SQ;
        return CLS_SQ;
      end
      if (cp && st == CLS_SQ && a == CH_SQUOTE) begin
        pend = CLS_DEFAULT;
        return CLS_SQ;
      end
      if (st != CLS_DEFAULT) begin
        pend = st;
        return st;
      end
      if (a >= CH_ZERO && a <= CH_NINE) begin
        pend = CLS_DEFAULT;
        cur = CLS_DIGITS;
        return CLS_DIGITS;
      end
      if (punct_byte(a)) begin
        pend = CLS_DEFAULT;
        cur = CLS_SYMBOL;
        return CLS_SYMBOL;
      end
      pend = st;
      return st;
    endfunction

    function void take_byte(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic s);
      if (s) begin
        cur = CLS_DEFAULT;
        pend = CLS_DEFAULT;
        skip = 2'd0;
      end
      classes_due.push_back(classify_byte(a, b, c));
    endfunction

    function void check_class(logic [3:0] got);
      cls_t want;
      if (classes_due.size() == 0) begin
        $display("%0t: class %0d arrived with nothing outstanding", $time, got);
        mismatches++;
        return;
      end
      want = classes_due.pop_front();
      checked++;
      classes_seen[want] = 1'b1;
      if (got !== want) begin
        $display("%0t: highlight_class mismatch: expected %0d (%s), actual %0d",
                 $time, want, want.name(), got);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return classes_due.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_now = 8'h00;
  logic [7:0] char_next = 8'h00;
  logic [7:0] char_after_next = 8'h00;
  logic       start_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] highlight_class;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] language_mode = 2'd0;

  highlight_tracker tracker;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned mode_writes = 0;
  logic [7:0] txt[$];

  syntax_highlight_classifier_unit dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .char_now        (char_now),
    .char_next       (char_next),
    .char_after_next (char_after_next),
    .start_of_text   (start_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .highlight_class (highlight_class),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .language_mode   (language_mode)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        tracker.take_byte(char_now, char_next, char_after_next, start_of_text);
      if (out_valid && !out_stall)
        tracker.check_class(highlight_class);
    end
  end

  // valid stays high between back-to-back items; only an idle cycle or wait_drained lowers it
  task automatic send_item(input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] c, input logic s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_now <= a;
    char_next <= b;
    char_after_next <= c;
    start_of_text <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < txt.size(); i++)
      send_item(txt[i], (i + 1 < txt.size()) ? txt[i + 1] : 8'h00,
                (i + 2 < txt.size()) ? txt[i + 2] : 8'h00, i == 0);
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  task automatic run_text(string s);
    txt.delete();
    add_str(s);
    send_text();
  endtask

  // token soup: mostly comment, string and quote marks with random filler
  task automatic build_text(input int unsigned len);
    string punct;
    punct = "{}[]()!$%^&*-+=:;@~#<>,.?/\\|'";
    txt.delete();
    while (txt.size() < len) begin
      case ($urandom_range(19))
        0: add_str("/*");
        1: add_str("*/");
        2: add_str("//");
        3: add_str("\n");
        4: add_str(";");
        5: add_str("#");
        6: add_str("\"");
        7: add_str("'");
        8: add_str("\\");
        9: add_str("\"\"\"");
        10: add_str("'''");
        11: add_str("=");
        12: add_str("==");
        13: add_str(" ");
        14: add_str("\t");
        15: txt.push_back(CH_ZERO + 8'($urandom_range(9)));
        16: txt.push_back(8'h61 + 8'($urandom_range(25)));
        17: begin
          if ($urandom_range(3) == 0) begin
            txt.push_back(8'hC2);
            txt.push_back(8'hA3);
          end else begin
            txt.push_back(punct[$urandom_range(punct.len() - 1)]);
          end
        end
        18: txt.push_back(8'($urandom_range(255)));
        default: repeat ($urandom_range(1, 4)) txt.push_back(8'h41 + 8'($urandom_range(25)));
      endcase
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  task automatic set_mode(input mode_t m);
    wait_drained();
    cfg_valid <= 1'b1;
    language_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.lang = m;
    mode_writes++;
  endtask

  initial begin
    int unsigned goal;
    int unsigned directed;
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: byte extremes, digits and pound sign, then each mode's constructs
    set_mode(MODE_NONE);
    send_item(8'h00, 8'hFF, 8'hFF, 1'b1);
    send_item(8'hFF, 8'h00, 8'h00, 1'b0);
    run_text("7\302\243");
    set_mode(MODE_C);
    run_text("/*a*/");
    run_text("\"\\\"\"");
    set_mode(MODE_LISP);
    // newline right after the comment mark is skipped, comment carries on
    run_text(";\nx\n");
    set_mode(MODE_PYTHON);
    run_text("=\"\"\"x\"\"\"");
    directed = bytes_sent;

    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 4; k++) begin
        case (ph)
          0: begin in_idle_pct = 0; out_stall_pct = 0; end
          1: begin in_idle_pct = 57; out_stall_pct = 0; end
          2: begin in_idle_pct = 0; out_stall_pct = 57; end
          default: begin in_idle_pct = 36; out_stall_pct = 36; end
        endcase
        set_mode(mode_t'((ph + k) % 4));
        goal = bytes_sent + 108;
        while (bytes_sent < goal) begin
          if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 6))
              send_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), $urandom_range(15) == 0);
          end else begin
            build_text($urandom_range(4, 40));
            send_text();
          end
        end
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("%0d bytes classified (%0d directed) over %0d language mode writes",
             tracker.checked, directed, mode_writes);
    $display("highlight classes seen (bit per class): %b", tracker.classes_seen);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0)
      $display("syntax_highlight_classifier_unit_tb: PASS");
    else
      $display("syntax_highlight_classifier_unit_tb: FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("timed out with %0d classes outstanding", tracker.outstanding());
    $display("syntax_highlight_classifier_unit_tb: FAIL");
    $finish;
  end

endmodule
